[sv/ipv4pc_pkg.sv]
// shared constants, operation codes and mask and length helpers for the ipv4 prefix compare block
package ipv4pc_pkg;

   localparam int ADDR_W  = 32;
   localparam int LEN_W   = 6;
   localparam int OP_W    = 4;
   localparam int ORDER_W = 7;

   localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(ADDR_W);
   localparam logic [ADDR_W-1:0] ALL_ONES  = '1;

   typedef enum logic [OP_W-1:0] {
      OP_ORDER     = 4'd0,
      OP_LT        = 4'd1,
      OP_LE        = 4'd2,
      OP_EQ        = 4'd3,
      OP_GE        = 4'd4,
      OP_GT        = 4'd5,
      OP_NE        = 4'd6,
      OP_SUB       = 4'd7,
      OP_SUBEQ     = 4'd8,
      OP_SUP       = 4'd9,
      OP_SUPEQ     = 4'd10,
      OP_BROADCAST = 4'd11,
      OP_NETWORK   = 4'd12,
      OP_NETMASK   = 4'd13
   } op_type;

   // top n bits set, n already limited to 0..32
   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] n);
      logic [LEN_W-1:0] sh;
      sh = LEN_MAX - n;
      if (n == '0) begin
         return '0;
      end
      return ALL_ONES << sh;
   endfunction

   // lengths above 32 count as 32
   function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] n);
      return (n > LEN_MAX) ? LEN_MAX : n;
   endfunction

endpackage

[sv/ipv4pc_if.sv]
// valid/ready channel interfaces for requests and results
interface ipv4pc_req_if;
   logic                              valid;
   logic                              ready;
   logic [ipv4pc_pkg::OP_W-1:0]       op;
   logic [ipv4pc_pkg::ADDR_W-1:0]     addr_a;
   logic [ipv4pc_pkg::LEN_W-1:0]      len_a;
   logic [ipv4pc_pkg::ADDR_W-1:0]     addr_b;
   logic [ipv4pc_pkg::LEN_W-1:0]      len_b;

   modport source (output valid, op, addr_a, len_a, addr_b, len_b, input ready);
   modport sink   (input valid, op, addr_a, len_a, addr_b, len_b, output ready);
endinterface

interface ipv4pc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ipv4pc_pkg::ORDER_W-1:0] order;
   logic                                 flag;
   logic [ipv4pc_pkg::ADDR_W-1:0]        addr_out;

   modport source (output valid, order, flag, addr_out, input ready);
   modport sink   (input valid, order, flag, addr_out, output ready);
endinterface

[sv/ipv4_prefix_compare.sv]
// ipv4 prefix compare: one request in, one result out, two register stages
//
// Each request carries an operation and two prefixes (address plus length 0..32,
// longer lengths count as 32). A request is taken into an input register, the
// masks, compares and operation select run in one pass of logic, and the answer
// lands in a result register. A new request is taken every cycle unless the result
// side stalls; a request's result passes through the input register and then the
// result register before it is presented. Throughput is one request per cycle,
// limited only by the result register draining. Unused result fields read as zero,
// and undefined operation codes give an all-zero result.
module ipv4_prefix_compare (
   input  logic             clock,
   input  logic             reset,
   ipv4pc_req_if.sink       req_chan,
   ipv4pc_rsp_if.source     rsp_chan
);

   // input register
   logic                               in_vld_ff, in_vld_in;
   logic [ipv4pc_pkg::OP_W-1:0]        in_op_ff;
   logic [ipv4pc_pkg::ADDR_W-1:0]      in_addr_a_ff, in_addr_b_ff;
   logic [ipv4pc_pkg::LEN_W-1:0]       in_len_a_ff, in_len_b_ff;

   // result register
   logic                                  rsp_vld_ff, rsp_vld_in;
   logic signed [ipv4pc_pkg::ORDER_W-1:0] order_ff, order_in;
   logic                                  flag_ff, flag_in;
   logic [ipv4pc_pkg::ADDR_W-1:0]         addr_out_ff, addr_out_in;

   // handshake
   logic out_free;
   logic move_up;
   logic req_take;

   // datapath
   logic [ipv4pc_pkg::LEN_W-1:0]          la, lb, shorter;
   logic [ipv4pc_pkg::ADDR_W-1:0]         mask_a, mask_b, mask_s;
   logic [ipv4pc_pkg::ADDR_W-1:0]         xa, xb;
   logic                                  match_a, match_b;
   logic signed [ipv4pc_pkg::ORDER_W-1:0] ord;

   // result register frees when empty or drained this cycle
   assign out_free = !rsp_vld_ff || rsp_chan.ready;
   assign move_up  = in_vld_ff && out_free;
   assign req_chan.ready = !in_vld_ff || out_free;
   assign req_take = req_chan.valid && req_chan.ready;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (move_up) begin
         in_vld_in = 1'b0;
      end
      rsp_vld_in = rsp_vld_ff;
      if (move_up) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   // masks for each length and for the shorter of the two
   always_comb begin
      la      = ipv4pc_pkg::sat_len(in_len_a_ff);
      lb      = ipv4pc_pkg::sat_len(in_len_b_ff);
      shorter = (la < lb) ? la : lb;
      mask_a  = ipv4pc_pkg::prefix_mask(la);
      mask_b  = ipv4pc_pkg::prefix_mask(lb);
      mask_s  = ipv4pc_pkg::prefix_mask(shorter);
      xa      = in_addr_a_ff & mask_s;
      xb      = in_addr_b_ff & mask_s;
      // top bits agree under each prefix length
      match_a = ((in_addr_a_ff ^ in_addr_b_ff) & mask_a) == '0;
      match_b = ((in_addr_a_ff ^ in_addr_b_ff) & mask_b) == '0;
      // three-way order: address difference first, else length difference
      if (xa < xb) begin
         ord = -7'sd1;
      end else if (xa > xb) begin
         ord = 7'sd1;
      end else begin
         ord = signed'({1'b0, la}) - signed'({1'b0, lb});
      end
   end

   // operation select
   always_comb begin
      order_in    = '0;
      flag_in     = 1'b0;
      addr_out_in = '0;
      case (in_op_ff)
         ipv4pc_pkg::OP_ORDER:     order_in = ord;
         ipv4pc_pkg::OP_LT:        flag_in  = ord < 0;
         ipv4pc_pkg::OP_LE:        flag_in  = ord <= 0;
         ipv4pc_pkg::OP_EQ:        flag_in  = ord == 0;
         ipv4pc_pkg::OP_GE:        flag_in  = ord >= 0;
         ipv4pc_pkg::OP_GT:        flag_in  = ord > 0;
         ipv4pc_pkg::OP_NE:        flag_in  = ord != 0;
         ipv4pc_pkg::OP_SUB:       flag_in  = (la > lb) && match_b;
         ipv4pc_pkg::OP_SUBEQ:     flag_in  = (la >= lb) && match_b;
         ipv4pc_pkg::OP_SUP:       flag_in  = (la < lb) && match_a;
         ipv4pc_pkg::OP_SUPEQ:     flag_in  = (la <= lb) && match_a;
         // /32 broadcast is the address itself since the host mask is empty
         ipv4pc_pkg::OP_BROADCAST: addr_out_in = in_addr_a_ff | ~mask_a;
         // /0 network comes out zero since the mask is empty
         ipv4pc_pkg::OP_NETWORK:   addr_out_in = in_addr_a_ff & mask_a;
         ipv4pc_pkg::OP_NETMASK:   addr_out_in = mask_a;
         default: begin
            order_in    = '0;
            flag_in     = 1'b0;
            addr_out_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      if (req_take) begin
         in_op_ff     <= req_chan.op;
         in_addr_a_ff <= req_chan.addr_a;
         in_len_a_ff  <= req_chan.len_a;
         in_addr_b_ff <= req_chan.addr_b;
         in_len_b_ff  <= req_chan.len_b;
      end
      if (move_up) begin
         order_ff    <= order_in;
         flag_ff     <= flag_in;
         addr_out_ff <= addr_out_in;
      end
   end

   assign rsp_chan.valid    = rsp_vld_ff;
   assign rsp_chan.order    = order_ff;
   assign rsp_chan.flag     = flag_ff;
   assign rsp_chan.addr_out = addr_out_ff;

   // an accepted request is held in the input register next cycle
   a_take_holds: assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_vld_ff)
      else $error("accepted request not held in input register");

   // a held request that cannot move up stays put
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !out_free) |=> (in_vld_ff && $stable(in_op_ff)
                                     && $stable(in_addr_a_ff)))
      else $error("stalled request lost from input register");

   // a request moving up yields a result next cycle
   a_move_result: assert property (@(posedge clock) disable iff (reset)
      move_up |=> rsp_vld_ff)
      else $error("request moved up but no result presented");

   // at most one result field carries a nonzero answer
   a_one_field: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> ($countones({order_ff != 0, flag_ff, addr_out_ff != 0}) <= 1))
      else $error("more than one result field active");

   // order stays within the length difference range
   a_order_range: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (order_ff >= -7'sd32 && order_ff <= 7'sd32))
      else $error("order result out of range");

endmodule

[verif/tb_top.sv]
// self-checking testbench for the ipv4 prefix compare block
`timescale 1ns / 1ps

module tb_top;

   // highest code the op field can carry, the two above OP_NETMASK are undefined
   localparam int OP_CODE_MAX = (1 << ipv4pc_pkg::OP_W) - 1;
   // the pipeline has two register stages, allow a few cycles more at the end
   localparam int DRAIN_CYCLES = 8;
   // length of the one long receiver hold-off, and when it starts
   localparam int HOLD_CYCLES = 40;
   localparam int HOLD_AFTER = 400;
   // the sender and receiver stop idling once the backlog gets this small
   localparam int QUIET_BACKLOG = 150;
   localparam int RANDOM_REQUESTS = 1400;

   typedef struct packed {
      logic [ipv4pc_pkg::OP_W-1:0]   op;
      logic [ipv4pc_pkg::ADDR_W-1:0] addr_a;
      logic [ipv4pc_pkg::LEN_W-1:0]  len_a;
      logic [ipv4pc_pkg::ADDR_W-1:0] addr_b;
      logic [ipv4pc_pkg::LEN_W-1:0]  len_b;
   } prefix_req_type;

   typedef struct packed {
      logic signed [ipv4pc_pkg::ORDER_W-1:0] order;
      logic                                  flag;
      logic [ipv4pc_pkg::ADDR_W-1:0]         addr_out;
   } prefix_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ipv4pc_req_if req_bus ();
   ipv4pc_rsp_if rsp_bus ();

   ipv4_prefix_compare i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // tb-side copies of the block's inputs, known from time zero
   logic           req_valid_q = 1'b0;
   prefix_req_type req_item_q  = '0;
   logic           rsp_ready_q = 1'b0;

   assign req_bus.valid  = req_valid_q;
   assign req_bus.op     = req_item_q.op;
   assign req_bus.addr_a = req_item_q.addr_a;
   assign req_bus.len_a  = req_item_q.len_a;
   assign req_bus.addr_b = req_item_q.addr_b;
   assign req_bus.len_b  = req_item_q.len_b;
   assign rsp_bus.ready  = rsp_ready_q;

   // requests waiting to be sent, and answers waiting to come back
   prefix_req_type request_backlog[$];
   prefix_rsp_type pending_answers[$];

   int   fail_count   = 0;
   int   sent_count   = 0;
   int   answer_count = 0;
   int   send_gap     = 0;
   int   recv_gap     = 0;
   int   hold_left    = 0;
   logic hold_done    = 1'b0;
   logic quiet_tail   = 1'b0;
   logic [OP_CODE_MAX:0] ops_seen = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // top n bits set, n in 0..32 (a shift by the full width gives zero)
   function automatic logic [ipv4pc_pkg::ADDR_W-1:0] top_bits_mask(
      input logic [ipv4pc_pkg::LEN_W-1:0] n);
      return ~(ipv4pc_pkg::ALL_ONES >> n);
   endfunction

   // expected answer of one request
   function automatic prefix_rsp_type compute_answer(input prefix_req_type r);
      logic [ipv4pc_pkg::LEN_W-1:0]  la;
      logic [ipv4pc_pkg::LEN_W-1:0]  lb;
      logic [ipv4pc_pkg::ADDR_W-1:0] mask_a;
      logic [ipv4pc_pkg::ADDR_W-1:0] mask_b;
      logic [ipv4pc_pkg::ADDR_W-1:0] mask_short;
      logic [ipv4pc_pkg::ADDR_W-1:0] diff;
      logic                          match_b;
      logic                          match_a;
      int                            ord;
      prefix_rsp_type                res;
      // lengths above 32 saturate before any use
      la = (r.len_a > ipv4pc_pkg::LEN_MAX) ? ipv4pc_pkg::LEN_MAX : r.len_a;
      lb = (r.len_b > ipv4pc_pkg::LEN_MAX) ? ipv4pc_pkg::LEN_MAX : r.len_b;
      mask_a = top_bits_mask(la);
      mask_b = top_bits_mask(lb);
      mask_short = (la < lb) ? mask_a : mask_b;
      diff = r.addr_a ^ r.addr_b;
      match_a = (diff & mask_a) == '0;
      match_b = (diff & mask_b) == '0;
      // three-way order on the shorter prefix, ties broken by length
      if ((r.addr_a & mask_short) < (r.addr_b & mask_short)) begin
         ord = -1;
      end else if ((r.addr_a & mask_short) > (r.addr_b & mask_short)) begin
         ord = 1;
      end else begin
         ord = int'(la) - int'(lb);
      end
      res = '0;
      case (r.op)
         ipv4pc_pkg::OP_ORDER:     res.order = ipv4pc_pkg::ORDER_W'(ord);
         ipv4pc_pkg::OP_LT:        res.flag = ord < 0;
         ipv4pc_pkg::OP_LE:        res.flag = ord <= 0;
         ipv4pc_pkg::OP_EQ:        res.flag = ord == 0;
         ipv4pc_pkg::OP_GE:        res.flag = ord >= 0;
         ipv4pc_pkg::OP_GT:        res.flag = ord > 0;
         ipv4pc_pkg::OP_NE:        res.flag = ord != 0;
         ipv4pc_pkg::OP_SUB:       res.flag = (la > lb) && match_b;
         ipv4pc_pkg::OP_SUBEQ:     res.flag = (la >= lb) && match_b;
         ipv4pc_pkg::OP_SUP:       res.flag = (la < lb) && match_a;
         ipv4pc_pkg::OP_SUPEQ:     res.flag = (la <= lb) && match_a;
         // a /32 broadcast is the address itself, a /0 network is zero
         ipv4pc_pkg::OP_BROADCAST: res.addr_out = r.addr_a | ~mask_a;
         ipv4pc_pkg::OP_NETWORK:   res.addr_out = r.addr_a & mask_a;
         ipv4pc_pkg::OP_NETMASK:   res.addr_out = mask_a;
         default:                  res = '0;
      endcase
      return res;
   endfunction

   task automatic queue_request(input int op, input logic [ipv4pc_pkg::ADDR_W-1:0] a,
                                input int la,
                                input logic [ipv4pc_pkg::ADDR_W-1:0] b, input int lb);
      prefix_req_type r;
      r.op = ipv4pc_pkg::OP_W'(op);
      r.addr_a = a;
      r.len_a = ipv4pc_pkg::LEN_W'(la);
      r.addr_b = b;
      r.len_b = ipv4pc_pkg::LEN_W'(lb);
      request_backlog.push_back(r);
   endtask

   // driver: offers the backlog in order, with random idle bursts
   always @(posedge clock) begin
      if (reset) begin
         req_valid_q <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid_q && req_bus.ready) begin
            // request accepted, its answer joins the tail of the expected queue
            pending_answers.push_back(compute_answer(req_item_q));
            ops_seen[req_item_q.op] <= 1'b1;
            sent_count <= sent_count + 1;
         end
         if (req_valid_q && !req_bus.ready) begin
            // block is stalled, keep the same request on the bus
         end else if (send_gap != 0) begin
            send_gap--;
            req_valid_q <= 1'b0;
         end else if (!quiet_tail && hold_left == 0 && $urandom_range(0, 7) == 0) begin
            // start an idle burst, this cycle included, its rest counted down in send_gap
            send_gap = $urandom_range(0, 3);
            req_valid_q <= 1'b0;
         end else if (request_backlog.size() != 0) begin
            req_item_q <= request_backlog.pop_front();
            req_valid_q <= 1'b1;
         end else begin
            req_valid_q <= 1'b0;
         end
      end
   end

   // one long receiver hold-off so the pipeline fills and stalls its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && sent_count >= HOLD_AFTER) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor: checks each result against the oldest expected answer
   always @(posedge clock) begin
      prefix_rsp_type want;
      if (reset) begin
         rsp_ready_q <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_bus.valid && rsp_ready_q) begin
            answer_count <= answer_count + 1;
            if (pending_answers.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("error: result with no request: order %0d flag %0b addr %h",
                           rsp_bus.order, rsp_bus.flag, rsp_bus.addr_out);
               end
            end else begin
               want = pending_answers.pop_front();
               if (rsp_bus.order !== want.order || rsp_bus.flag !== want.flag ||
                   rsp_bus.addr_out !== want.addr_out) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("error: mismatch, expected order %0d flag %0b addr %h",
                              want.order, want.flag, want.addr_out);
                     $display("       actual   order %0d flag %0b addr %h",
                              rsp_bus.order, rsp_bus.flag, rsp_bus.addr_out);
                  end
               end
            end
         end
         // back-pressure: long hold-off first, then random stall bursts
         if (hold_left != 0) begin
            rsp_ready_q <= 1'b0;
         end else if (recv_gap != 0) begin
            recv_gap--;
            rsp_ready_q <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(0, 3);
            rsp_ready_q <= 1'b0;
         end else begin
            rsp_ready_q <= 1'b1;
         end
      end
   end

   // stimulus and end of run
   initial begin
      prefix_req_type                r;
      logic [ipv4pc_pkg::ADDR_W-1:0] a;
      logic [ipv4pc_pkg::ADDR_W-1:0] b;
      int                            kind;
      int                            op;
      int                            ops_hit;

      // directed: every op code on a /24 inside a /16
      for (int i = 0; i <= OP_CODE_MAX; i++) begin
         queue_request(i, 32'hc0a8_0101, 24, 32'hc0a8_0000, 16);
      end
      // broadcast of a /32 is the address itself, of a /0 all ones
      queue_request(ipv4pc_pkg::OP_BROADCAST, 32'h0a00_0001, 32, 32'h0, 0);
      queue_request(ipv4pc_pkg::OP_BROADCAST, 32'h0a00_0001, 0, ipv4pc_pkg::ALL_ONES, 32);
      // network and netmask of a /0 are zero
      queue_request(ipv4pc_pkg::OP_NETWORK, ipv4pc_pkg::ALL_ONES, 0,
                    ipv4pc_pkg::ALL_ONES, 32);
      queue_request(ipv4pc_pkg::OP_NETMASK, ipv4pc_pkg::ALL_ONES, 0, 32'h0, 63);
      // over-long length counts as 32, also in the length difference
      queue_request(ipv4pc_pkg::OP_NETMASK, 32'h0, 63, 32'h0, 0);
      queue_request(ipv4pc_pkg::OP_ORDER, 32'h0, 63, ipv4pc_pkg::ALL_ONES, 0);
      // extreme order results
      queue_request(ipv4pc_pkg::OP_ORDER, 32'h0, 0, ipv4pc_pkg::ALL_ONES, 32);
      queue_request(ipv4pc_pkg::OP_ORDER, 32'h0, 32, ipv4pc_pkg::ALL_ONES, 32);
      queue_request(ipv4pc_pkg::OP_EQ, ipv4pc_pkg::ALL_ONES, 32, ipv4pc_pkg::ALL_ONES, 33);
      queue_request(ipv4pc_pkg::OP_SUPEQ, 32'h8000_0000, 1, ipv4pc_pkg::ALL_ONES, 32);

      // random: mostly related address pairs so order ties and containment happen
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         a = $urandom();
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            b = $urandom();
         end else if (kind < 8) begin
            b = a ^ ($urandom() & ~top_bits_mask(
                   ipv4pc_pkg::LEN_W'($urandom_range(0, ipv4pc_pkg::ADDR_W))));
         end else if (kind == 8) begin
            b = a;
         end else begin
            b = a ^ (32'h8000_0000 >> $urandom_range(0, ipv4pc_pkg::ADDR_W - 1));
         end
         if ($urandom_range(0, 19) == 0) begin
            op = $urandom_range(ipv4pc_pkg::OP_NETMASK + 1, OP_CODE_MAX);
         end else begin
            op = $urandom_range(ipv4pc_pkg::OP_ORDER, ipv4pc_pkg::OP_NETMASK);
         end
         r.op = ipv4pc_pkg::OP_W'(op);
         r.addr_a = a;
         r.addr_b = b;
         r.len_a = ($urandom_range(0, 6) == 0)
                   ? ipv4pc_pkg::LEN_W'($urandom_range(ipv4pc_pkg::ADDR_W + 1, 63))
                   : ipv4pc_pkg::LEN_W'($urandom_range(0, ipv4pc_pkg::ADDR_W));
         r.len_b = ($urandom_range(0, 6) == 0)
                   ? ipv4pc_pkg::LEN_W'($urandom_range(ipv4pc_pkg::ADDR_W + 1, 63))
                   : ipv4pc_pkg::LEN_W'($urandom_range(0, ipv4pc_pkg::ADDR_W));
         request_backlog.push_back(r);
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // no idling on either side for the tail of the run
      while (request_backlog.size() > QUIET_BACKLOG) @(posedge clock);
      quiet_tail <= 1'b1;

      // wait for the last answers, then a few cycles for any stray result
      while (request_backlog.size() != 0 || req_valid_q || pending_answers.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      ops_hit = 0;
      for (int i = 0; i <= OP_CODE_MAX; i++) begin
         if (ops_seen[i]) ops_hit++;
      end
      $display("run covered %0d requests over %0d op codes, %0d results checked",
               sent_count, ops_hit, answer_count);
      $display("includes a %0d-cycle result hold-off, %0d failures counted",
               HOLD_CYCLES, fail_count);
      if (fail_count == 0 && pending_answers.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // watchdog far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("error: timeout with %0d answers outstanding", pending_answers.size());
      $display("status: fail");
      $finish;
   end

endmodule
